// ----- rtl/core/cpt_pkg.sv -----
package cpt_pkg;

  // queue between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // difference vector codes (order of the packed request word)
  localparam logic [3:0] V_AB = 4'd0;
  localparam logic [3:0] V_AC = 4'd1;
  localparam logic [3:0] V_AP = 4'd2;
  localparam logic [3:0] V_BP = 4'd3;
  localparam logic [3:0] V_CP = 4'd4;
  localparam logic [3:0] V_BC = 4'd5;

  // vertex codes
  localparam logic [1:0] K_A = 2'd0;
  localparam logic [1:0] K_B = 2'd1;
  localparam logic [1:0] K_C = 2'd2;

  // back-end register file slots
  localparam logic [3:0] R_D1  = 4'd0;
  localparam logic [3:0] R_D2  = 4'd1;
  localparam logic [3:0] R_D3  = 4'd2;
  localparam logic [3:0] R_D4  = 4'd3;
  localparam logic [3:0] R_D5  = 4'd4;
  localparam logic [3:0] R_D6  = 4'd5;
  localparam logic [3:0] R_VA  = 4'd6;
  localparam logic [3:0] R_VB  = 4'd7;
  localparam logic [3:0] R_VC  = 4'd8;
  localparam logic [3:0] R_NUM = 4'd9;
  localparam logic [3:0] R_DEN = 4'd10;
  localparam int         N_REG = 11;

  // feature codes
  localparam logic [2:0] FEAT_A    = 3'd0;
  localparam logic [2:0] FEAT_B    = 3'd1;
  localparam logic [2:0] FEAT_AB   = 3'd2;
  localparam logic [2:0] FEAT_C    = 3'd3;
  localparam logic [2:0] FEAT_AC   = 3'd4;
  localparam logic [2:0] FEAT_BC   = 3'd5;
  localparam logic [2:0] FEAT_FACE = 3'd6;

  // one multiply-accumulate step of the region program
  typedef struct packed {
    logic       clr;   // start a fresh sum
    logic       neg;   // subtract the product
    logic       st;    // write the sum back when done
    logic [3:0] dst;
    logic       xr;    // x from register file, else from a difference vector
    logic [3:0] xi;
    logic       yr;
    logic [3:0] yi;
    logic [1:0] comp;  // vector component
  } mop_t;

  localparam logic [4:0] LAST_STEP = 5'd23;

  function automatic mop_t mk(input logic clr, input logic neg, input logic st,
                              input logic [3:0] dst, input logic xr, input logic [3:0] xi,
                              input logic yr, input logic [3:0] yi, input logic [1:0] comp);
    mop_t m;
    m.clr  = clr;
    m.neg  = neg;
    m.st   = st;
    m.dst  = dst;
    m.xr   = xr;
    m.xi   = xi;
    m.yr   = yr;
    m.yi   = yi;
    m.comp = comp;
    return m;
  endfunction

  // six dot products, then the three barycentric cross terms
  function automatic mop_t mop(input logic [4:0] s);
    mop_t m;
    case (s)
      5'd0:  m = mk(1'b1, 1'b0, 1'b0, R_D1, 1'b0, V_AB, 1'b0, V_AP, 2'd0);
      5'd1:  m = mk(1'b0, 1'b0, 1'b0, R_D1, 1'b0, V_AB, 1'b0, V_AP, 2'd1);
      5'd2:  m = mk(1'b0, 1'b0, 1'b1, R_D1, 1'b0, V_AB, 1'b0, V_AP, 2'd2);
      5'd3:  m = mk(1'b1, 1'b0, 1'b0, R_D2, 1'b0, V_AC, 1'b0, V_AP, 2'd0);
      5'd4:  m = mk(1'b0, 1'b0, 1'b0, R_D2, 1'b0, V_AC, 1'b0, V_AP, 2'd1);
      5'd5:  m = mk(1'b0, 1'b0, 1'b1, R_D2, 1'b0, V_AC, 1'b0, V_AP, 2'd2);
      5'd6:  m = mk(1'b1, 1'b0, 1'b0, R_D3, 1'b0, V_AB, 1'b0, V_BP, 2'd0);
      5'd7:  m = mk(1'b0, 1'b0, 1'b0, R_D3, 1'b0, V_AB, 1'b0, V_BP, 2'd1);
      5'd8:  m = mk(1'b0, 1'b0, 1'b1, R_D3, 1'b0, V_AB, 1'b0, V_BP, 2'd2);
      5'd9:  m = mk(1'b1, 1'b0, 1'b0, R_D4, 1'b0, V_AC, 1'b0, V_BP, 2'd0);
      5'd10: m = mk(1'b0, 1'b0, 1'b0, R_D4, 1'b0, V_AC, 1'b0, V_BP, 2'd1);
      5'd11: m = mk(1'b0, 1'b0, 1'b1, R_D4, 1'b0, V_AC, 1'b0, V_BP, 2'd2);
      5'd12: m = mk(1'b1, 1'b0, 1'b0, R_D5, 1'b0, V_AB, 1'b0, V_CP, 2'd0);
      5'd13: m = mk(1'b0, 1'b0, 1'b0, R_D5, 1'b0, V_AB, 1'b0, V_CP, 2'd1);
      5'd14: m = mk(1'b0, 1'b0, 1'b1, R_D5, 1'b0, V_AB, 1'b0, V_CP, 2'd2);
      5'd15: m = mk(1'b1, 1'b0, 1'b0, R_D6, 1'b0, V_AC, 1'b0, V_CP, 2'd0);
      5'd16: m = mk(1'b0, 1'b0, 1'b0, R_D6, 1'b0, V_AC, 1'b0, V_CP, 2'd1);
      5'd17: m = mk(1'b0, 1'b0, 1'b1, R_D6, 1'b0, V_AC, 1'b0, V_CP, 2'd2);
      5'd18: m = mk(1'b1, 1'b0, 1'b0, R_VC, 1'b1, R_D1, 1'b1, R_D4, 2'd0);
      5'd19: m = mk(1'b0, 1'b1, 1'b1, R_VC, 1'b1, R_D3, 1'b1, R_D2, 2'd0);
      5'd20: m = mk(1'b1, 1'b0, 1'b0, R_VB, 1'b1, R_D5, 1'b1, R_D2, 2'd0);
      5'd21: m = mk(1'b0, 1'b1, 1'b1, R_VB, 1'b1, R_D1, 1'b1, R_D6, 2'd0);
      5'd22: m = mk(1'b1, 1'b0, 1'b0, R_VA, 1'b1, R_D3, 1'b1, R_D6, 2'd0);
      5'd23: m = mk(1'b0, 1'b1, 1'b1, R_VA, 1'b1, R_D5, 1'b1, R_D4, 2'd0);
      default: m = mk(1'b0, 1'b0, 1'b0, R_D1, 1'b0, V_AB, 1'b0, V_AB, 2'd0);
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/cpt_front.sv -----
module cpt_front
  import cpt_pkg::*;
#(
  parameter int COORD_BITS = 32,
  localparam int W  = COORD_BITS,
  localparam int D  = COORD_BITS + 1,
  localparam int IW = 18 * D + 9 * COORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [W-1:0] in_px,
  input  logic signed [W-1:0] in_py,
  input  logic signed [W-1:0] in_pz,
  input  logic signed [W-1:0] in_ax,
  input  logic signed [W-1:0] in_ay,
  input  logic signed [W-1:0] in_az,
  input  logic signed [W-1:0] in_bx,
  input  logic signed [W-1:0] in_by,
  input  logic signed [W-1:0] in_bz,
  input  logic signed [W-1:0] in_cx,
  input  logic signed [W-1:0] in_cy,
  input  logic signed [W-1:0] in_cz,
  input  qstat_t              qst,
  output logic                push,
  output logic [IW-1:0]       dout
);

  logic          fv_r, fv_nxt;
  logic [IW-1:0] fd_r, fd_nxt;
  logic          accept;
  logic signed [D-1:0] pv [3];
  logic signed [D-1:0] av [3];
  logic signed [D-1:0] bv [3];
  logic signed [D-1:0] cv [3];

  assign busy   = fv_r & qst.full;
  assign accept = start & ~busy;
  assign push   = fv_r & ~qst.full;
  assign fv_nxt = accept | (fv_r & qst.full);
  assign dout   = fd_r;

  always_comb begin
    pv[0] = D'(in_px); pv[1] = D'(in_py); pv[2] = D'(in_pz);
    av[0] = D'(in_ax); av[1] = D'(in_ay); av[2] = D'(in_az);
    bv[0] = D'(in_bx); bv[1] = D'(in_by); bv[2] = D'(in_bz);
    cv[0] = D'(in_cx); cv[1] = D'(in_cy); cv[2] = D'(in_cz);
  end

  // difference vectors one bit wider than a coordinate, then the vertices
  always_comb begin
    fd_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      fd_nxt[(int'(V_AB) * 3 + c) * D +: D] = bv[c] - av[c];
      fd_nxt[(int'(V_AC) * 3 + c) * D +: D] = cv[c] - av[c];
      fd_nxt[(int'(V_AP) * 3 + c) * D +: D] = pv[c] - av[c];
      fd_nxt[(int'(V_BP) * 3 + c) * D +: D] = pv[c] - bv[c];
      fd_nxt[(int'(V_CP) * 3 + c) * D +: D] = pv[c] - cv[c];
      fd_nxt[(int'(V_BC) * 3 + c) * D +: D] = cv[c] - bv[c];
      fd_nxt[18 * D + (int'(K_A) * 3 + c) * W +: W] = av[c][W-1:0];
      fd_nxt[18 * D + (int'(K_B) * 3 + c) * W +: W] = bv[c][W-1:0];
      fd_nxt[18 * D + (int'(K_C) * 3 + c) * W +: W] = cv[c][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fd_r <= fd_nxt;
    end
  end

endmodule

// ----- rtl/core/cpt_queue.sv -----
module cpt_queue
  import cpt_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output qstat_t        qst
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [DW-1:0] ent_r [Q_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign qst.empty = (cnt_r == '0);
  assign qst.full  = (cnt_r == CW'(Q_DEPTH));
  assign dout      = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) qst.full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) qst.empty |-> !pop)
    else $error("queue read while empty");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !qst.empty)
    else $error("queue lost a request");

endmodule

// ----- rtl/core/cpt_back.sv -----
module cpt_back
  import cpt_pkg::*;
#(
  parameter int COORD_BITS = 32,
  localparam int W  = COORD_BITS,
  localparam int D  = COORD_BITS + 1,
  localparam int IW = 18 * D + 9 * COORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IW-1:0]       head,
  input  qstat_t              qst,
  output logic                pop,
  output logic                out_valid,
  output logic signed [W-1:0] out_qx,
  output logic signed [W-1:0] out_qy,
  output logic signed [W-1:0] out_qz,
  output logic [2:0]          out_feature
);

  localparam int MW   = 2 * D + 2;   // multiplier operand width
  localparam int BW   = 5 * D + 8;   // exact width of every sum
  localparam int CNTW = $clog2(BW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_CLS1 = 4'd3;
  localparam logic [3:0] S_CLS2 = 4'd4;
  localparam logic [3:0] S_DLD  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;

  logic [3:0]      state_r, state_nxt;
  logic [4:0]      step_r, step_nxt;
  logic            crd_r, crd_nxt;
  logic [1:0]      ci_r, ci_nxt;
  logic            pi_r, pi_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            vld_r, vld_nxt;

  logic signed [BW-1:0] acc_r, m_r;
  logic [MW-1:0]        y_r;
  logic                 neg_r;
  logic signed [BW-1:0] rg_r [N_REG];
  logic signed [BW-1:0] t1_r, t2_r, t12_r, e13_r, e26_r, sab_r;
  logic [2:0]           feat_r;
  logic [1:0]           base_r;
  logic [3:0]           ev_r;
  logic                 face_r, dz_r, sgn_r;
  logic [BW-1:0]        ud_r, quo_r, rem_r;
  logic signed [BW-1:0] off_r;
  logic signed [W-1:0]  qc_r [3];

  mop_t                 op;
  logic signed [BW-1:0] xs, acc_nxt, den_c, num_c;
  logic [MW-1:0]        ys;
  logic                 mul_last, sub;
  logic [2:0]           feat_c;
  logic [1:0]           base_c;
  logic [3:0]           ev_c;
  logic                 face_c;
  logic [BW:0]          rs, dif;
  logic                 rnd;
  logic signed [BW:0]   sum;
  logic signed [W-1:0]  sat;

  function automatic logic signed [D-1:0] dvec(input logic [IW-1:0] h, input logic [3:0] v,
                                               input logic [1:0] c);
    int idx;
    idx = (int'(v) * 3 + int'(c)) * D;
    return h[idx +: D];
  endfunction

  function automatic logic signed [W-1:0] vert(input logic [IW-1:0] h, input logic [1:0] k,
                                               input logic [1:0] c);
    int idx;
    idx = 18 * D + (int'(k) * 3 + int'(c)) * W;
    return h[idx +: W];
  endfunction

  function automatic logic le0(input logic signed [BW-1:0] x);
    return x[BW-1] || (x == '0);
  endfunction

  // operand selection: region program, or per-axis numerator
  always_comb begin
    if (crd_r) begin
      op = mk(~pi_r, 1'b0, 1'b0, R_NUM, 1'b1,
              pi_r ? R_VC : (face_r ? R_VB : R_NUM), 1'b0,
              pi_r ? V_AC : (face_r ? V_AB : ev_r), ci_r);
    end else begin
      op = mop(step_r);
    end
    xs = op.xr ? rg_r[op.xi] : BW'(dvec(head, op.xi, op.comp));
    ys = op.yr ? rg_r[op.yi][MW-1:0] : MW'(dvec(head, op.yi, op.comp));
  end

  // shift-add multiply, top bit of y has negative weight
  assign mul_last = (cnt_r == CNTW'(MW - 1));
  assign sub      = mul_last ^ neg_r;
  assign acc_nxt  = y_r[0] ? (sub ? acc_r - m_r : acc_r + m_r) : acc_r;

  // Voronoi region choice, tested in priority order
  always_comb begin
    feat_c = FEAT_FACE;
    base_c = K_A;
    ev_c   = V_AB;
    num_c  = '0;
    den_c  = sab_r + rg_r[R_VC];
    face_c = 1'b1;
    if (le0(rg_r[R_D1]) && le0(rg_r[R_D2])) begin
      feat_c = FEAT_A;
      den_c  = '0;
      face_c = 1'b0;
    end else if (!rg_r[R_D3][BW-1] && !rg_r[R_D4][BW-1]) begin
      feat_c = FEAT_B;
      base_c = K_B;
      den_c  = '0;
      face_c = 1'b0;
    end else if (le0(rg_r[R_VC]) && !rg_r[R_D1][BW-1] && le0(rg_r[R_D3])) begin
      feat_c = FEAT_AB;
      num_c  = rg_r[R_D1];
      den_c  = e13_r;
      face_c = 1'b0;
    end else if (!rg_r[R_D6][BW-1] && le0(t2_r)) begin
      feat_c = FEAT_C;
      base_c = K_C;
      den_c  = '0;
      face_c = 1'b0;
    end else if (le0(rg_r[R_VB]) && !rg_r[R_D2][BW-1] && le0(rg_r[R_D6])) begin
      feat_c = FEAT_AC;
      ev_c   = V_AC;
      num_c  = rg_r[R_D2];
      den_c  = e26_r;
      face_c = 1'b0;
    end else if (le0(rg_r[R_VA]) && !t1_r[BW-1] && !t2_r[BW-1]) begin
      feat_c = FEAT_BC;
      base_c = K_B;
      ev_c   = V_BC;
      num_c  = t1_r;
      den_c  = t12_r;
      face_c = 1'b0;
    end
  end

  // restoring divide step and rounding
  assign rs  = {rem_r, quo_r[BW-1]};
  assign dif = rs - {1'b0, ud_r};
  assign rnd = ({rem_r, 1'b0} >= {1'b0, ud_r});

  // base plus offset, clamped to the coordinate range
  always_comb begin
    sum = (BW + 1)'(vert(head, base_r, ci_r)) + (BW + 1)'(off_r);
    if ((&sum[BW:W-1]) || !(|sum[BW:W-1])) begin
      sat = sum[W-1:0];
    end else if (sum[BW]) begin
      sat = {1'b1, {(W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(W - 1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    crd_nxt   = crd_r;
    ci_nxt    = ci_r;
    pi_nxt    = pi_r;
    cnt_nxt   = cnt_r;
    vld_nxt   = 1'b0;
    pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!qst.empty) begin
          step_nxt  = '0;
          crd_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (mul_last) begin
          if (!crd_r) begin
            if (step_r == LAST_STEP) begin
              state_nxt = S_CLS1;
            end else begin
              step_nxt  = step_r + 1'b1;
              state_nxt = S_LOAD;
            end
          end else if (!pi_r && face_r) begin
            pi_nxt    = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_DLD;
          end
        end
      end
      S_CLS1: state_nxt = S_CLS2;
      S_CLS2: begin
        crd_nxt   = 1'b1;
        ci_nxt    = '0;
        pi_nxt    = 1'b0;
        state_nxt = S_LOAD;
      end
      S_DLD: begin
        cnt_nxt   = '0;
        state_nxt = dz_r ? S_SUM : S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(BW - 1)) begin
          state_nxt = S_RND;
        end
      end
      S_RND: state_nxt = S_SUM;
      S_SUM: begin
        if (ci_r == 2'd2) begin
          vld_nxt   = 1'b1;
          pop       = 1'b1;
          crd_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          pi_nxt    = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      crd_r   <= 1'b0;
      ci_r    <= '0;
      pi_r    <= 1'b0;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      crd_r   <= crd_nxt;
      ci_r    <= ci_nxt;
      pi_r    <= pi_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        m_r   <= xs;
        y_r   <= ys;
        neg_r <= op.neg;
        if (op.clr) begin
          acc_r <= '0;
        end
      end
      S_MUL: begin
        acc_r <= acc_nxt;
        m_r   <= m_r <<< 1;
        y_r   <= y_r >> 1;
        if (mul_last && op.st) begin
          rg_r[op.dst] <= acc_nxt;
        end
      end
      S_CLS1: begin
        t1_r  <= rg_r[R_D4] - rg_r[R_D3];
        t2_r  <= rg_r[R_D5] - rg_r[R_D6];
        t12_r <= (rg_r[R_D4] - rg_r[R_D3]) + (rg_r[R_D5] - rg_r[R_D6]);
        e13_r <= rg_r[R_D1] - rg_r[R_D3];
        e26_r <= rg_r[R_D2] - rg_r[R_D6];
        sab_r <= rg_r[R_VA] + rg_r[R_VB];
      end
      S_CLS2: begin
        feat_r      <= feat_c;
        base_r      <= base_c;
        ev_r        <= ev_c;
        face_r      <= face_c;
        rg_r[R_NUM] <= num_c;
        rg_r[R_DEN] <= den_c;
        dz_r        <= (den_c == '0);
      end
      S_DLD: begin
        quo_r <= acc_r[BW-1] ? BW'('0 - acc_r) : acc_r;
        ud_r  <= rg_r[R_DEN][BW-1] ? BW'('0 - rg_r[R_DEN]) : rg_r[R_DEN];
        sgn_r <= acc_r[BW-1] ^ rg_r[R_DEN][BW-1];
        rem_r <= '0;
        if (dz_r) begin
          off_r <= '0;
        end
      end
      S_DIV: begin
        rem_r <= dif[BW] ? rs[BW-1:0] : dif[BW-1:0];
        quo_r <= {quo_r[BW-2:0], ~dif[BW]};
      end
      S_RND: begin
        off_r <= sgn_r ? (~quo_r + BW'(!rnd)) : (quo_r + BW'(rnd));
      end
      S_SUM: begin
        qc_r[ci_r] <= sat;
      end
      default: ;
    endcase
  end

  assign out_valid   = vld_r;
  assign out_qx      = qc_r[0];
  assign out_qy      = qc_r[1];
  assign out_qz      = qc_r[2];
  assign out_feature = feat_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n) vld_r |=> !vld_r)
    else $error("result strobe held for two cycles");
  a_pop_with_result: assert property (@(posedge clk) disable iff (!rst_n) pop |=> vld_r)
    else $error("request retired without a result");

endmodule

// ----- rtl/core/closest_point_on_triangle.sv -----
// Channel   Ports                          Handshake
// -------   -----------------------------  ---------------------------------
// request   in_px..in_cz                   taken at an edge with start && !busy
// result    out_qx/qy/qz, out_feature      out_valid high for one cycle
//
// Datapath: the back end does every product on one shift-add multiplier
// (one bit of y per cycle, MW = 2*COORD_BITS+4 bits) and every quotient on
// one restoring divider (BW = 5*COORD_BITS+13 bits). Each axis of the result
// takes two products on the face and one elsewhere; a zero denominator
// (vertex cases, flat face) skips the divide and round.
// Reset: rst_n, synchronous, clears all control; the queue comes up empty.
// Stalls: busy rises only when the front register and the queue are full.
// The receiver cannot stall; a result is shown for exactly one cycle.
module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_az,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_bz,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic signed [COORD_BITS-1:0] in_cz,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_qx,
  output logic signed [COORD_BITS-1:0] out_qy,
  output logic signed [COORD_BITS-1:0] out_qz,
  output logic [2:0]                   out_feature
);

  // packed request: 18 difference components, then the three vertices
  localparam int D  = COORD_BITS + 1;
  localparam int IW = 18 * D + 9 * COORD_BITS;

  logic          push, pop;
  logic [IW-1:0] fdata, head;
  qstat_t        qst;

  // front: takes the request, forms edge and point vectors
  cpt_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .in_px (in_px), .in_py (in_py), .in_pz (in_pz),
    .in_ax (in_ax), .in_ay (in_ay), .in_az (in_az),
    .in_bx (in_bx), .in_by (in_by), .in_bz (in_bz),
    .in_cx (in_cx), .in_cy (in_cy), .in_cz (in_cz),
    .qst   (qst),
    .push  (push),
    .dout  (fdata)
  );

  // short queue decouples the front from the long back-end sequence
  cpt_queue #(.DW(IW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (fdata),
    .pop   (pop),
    .dout  (head),
    .qst   (qst)
  );

  // back: dot products, region test, per-axis divide and clamp
  cpt_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .qst         (qst),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_qx      (out_qx),
    .out_qy      (out_qy),
    .out_qz      (out_qz),
    .out_feature (out_feature)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import cpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Exact math width: coords 32b, dots ~67b, cross terms ~136b, face numerators ~170b.
  localparam int WB        = 320;
  localparam int U         = 65536;              // 1.0 in Q16.16
  localparam int N_RANDOM  = 1825;
  localparam int DRAIN_AT  = 900;                // sender pauses here until queue drains
  localparam int WD_LIMIT  = 50000;              // cycles with no handshake at all
  localparam int TAIL_WAIT = 3000;               // extra wait after the last result

  typedef logic signed [WB-1:0] wide_t;
  typedef logic signed [31:0]   coord_t;
  typedef coord_t               tri_req_t [12];  // px py pz ax ay az bx by bz cx cy cz

  typedef struct {
    coord_t     qx, qy, qz;
    logic [2:0] feat;
  } near_pt_t;

  typedef struct {
    tri_req_t req;
    bit       typed;   // expected point written in by hand
    near_pt_t pt;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_px, in_py, in_pz, in_ax, in_ay, in_az;
  coord_t in_bx, in_by, in_bz, in_cx, in_cy, in_cz;
  logic   out_valid;
  coord_t out_qx, out_qy, out_qz;
  logic [2:0] out_feature;

  near_pt_t  pending_pts[$];   // expected points, oldest first
  stim_row_t stim_rows[$];
  int        n_err = 0;
  int        n_sent = 0;
  int        n_seen = 0;
  int        feat_seen[7];
  int        idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  closest_point_on_triangle i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_px(in_px), .in_py(in_py), .in_pz(in_pz),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_feature(out_feature)
  );

  // ---------------------------------------------------------------------------
  // Predictor: exact integer Voronoi-region walk at WB bits.
  // ---------------------------------------------------------------------------
  function automatic wide_t dot3(input wide_t x0, x1, x2, y0, y1, y2);
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  // signed n/d, round to nearest, ties away from zero; zero divisor gives zero offset
  function automatic wide_t div_near(input wide_t n, input wide_t d);
    wide_t un, ud, q, r;
    if (d == 0) return '0;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = un / ud;
    r  = un % ud;
    if (2 * r >= ud) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic coord_t clamp32(input wide_t x);
    if (x > wide_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (x < wide_t'(-33'sh80000000)) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic near_pt_t nearest_on_tri(input tri_req_t r);
    wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
    wide_t base[3], dir[3];
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, t1, t2, num, den;
    near_pt_t o;
    bit face;
    face = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p[i] = r[i]; a[i] = r[3+i]; b[i] = r[6+i]; c[i] = r[9+i];
      ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i]; bc[i] = c[i] - b[i];
    end
    num = 0; den = 0;
    base = a; dir = ab;
    d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
    d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
    d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
    d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
    d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
    d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    t1 = d4 - d3;
    t2 = d5 - d6;
    if (d1 <= 0 && d2 <= 0) begin
      o.feat = FEAT_A;
    end else if (d3 >= 0 && d4 >= 0) begin
      o.feat = FEAT_B; base = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      o.feat = FEAT_AB; num = d1; den = d1 - d3;
    end else if (d6 >= 0 && t2 <= 0) begin
      o.feat = FEAT_C; base = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      o.feat = FEAT_AC; dir = ac; num = d2; den = d2 - d6;
    end else if (va <= 0 && t1 >= 0 && t2 >= 0) begin
      o.feat = FEAT_BC; base = b; dir = bc; num = t1; den = t1 + t2;
    end else begin
      o.feat = FEAT_FACE; face = 1'b1; den = va + vb + vc;
    end
    for (int i = 0; i < 3; i++) begin
      wide_t q;
      // face: a + (vb*ab + vc*ac)/den; degenerate face falls back to vertex a
      if (face) q = a[i] + div_near(vb * ab[i] + vc * ac[i], den);
      else      q = base[i] + div_near(num * dir[i], den);
      if (i == 0) o.qx = clamp32(q);
      else if (i == 1) o.qy = clamp32(q);
      else o.qz = clamp32(q);
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      near_pt_t e;
      if (pending_pts.size() == 0) begin
        $error("result with no request outstanding: q=(%0d,%0d,%0d) feature=%0d",
               out_qx, out_qy, out_qz, out_feature);
        n_err++;
      end else begin
        e = pending_pts.pop_front();
        if (out_qx !== e.qx) begin
          $error("qx: expected %0d, got %0d", e.qx, out_qx); n_err++;
        end
        if (out_qy !== e.qy) begin
          $error("qy: expected %0d, got %0d", e.qy, out_qy); n_err++;
        end
        if (out_qz !== e.qz) begin
          $error("qz: expected %0d, got %0d", e.qz, out_qz); n_err++;
        end
        if (out_feature !== e.feat) begin
          $error("feature: expected %0d, got %0d", e.feat, out_feature); n_err++;
        end
      end
      if (out_feature < 7) feat_seen[out_feature]++;
      n_seen++;
    end
    // watchdog: any handshake on either side restarts the count
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no activity for %0d cycles, %0d requests outstanding",
               WD_LIMIT, pending_pts.size());
      $display("** closest_point_on_triangle: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Drives on the falling edge; start stays high between back-to-back
  // requests and only drops when a gap follows.
  // ---------------------------------------------------------------------------
  task automatic send_req(input tri_req_t r, input bit typed, input near_pt_t pt);
    @(negedge clk);
    {in_px, in_py, in_pz} = {r[0], r[1], r[2]};
    {in_ax, in_ay, in_az} = {r[3], r[4], r[5]};
    {in_bx, in_by, in_bz} = {r[6], r[7], r[8]};
    {in_cx, in_cy, in_cz} = {r[9], r[10], r[11]};
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pts.push_back(typed ? pt : nearest_on_tri(r));
    n_sent++;
  endtask

  task automatic gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly back-to-back or short, now and then a long hole
  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // random magnitude: full 32-bit down to a few LSBs
  function automatic coord_t rand_coord();
    return coord_t'($urandom) >>> $urandom_range(0, 28);
  endfunction

  function automatic tri_req_t rand_req();
    tri_req_t r;
    int mode, k;
    mode = $urandom_range(0, 99);
    for (int i = 0; i < 12; i++) r[i] = rand_coord();
    if (mode < 15) begin
      // raw 32-bit noise, every bit toggles
      for (int i = 0; i < 12; i++) r[i] = $urandom;
    end else if (mode < 65) begin
      // well-formed small triangle with p around it: hits all seven regions
      for (int i = 3; i < 12; i++) r[i] = $signed($urandom_range(0, 8 * U)) - 4 * U;
      for (int i = 0; i < 3; i++)  r[i] = $signed($urandom_range(0, 16 * U)) - 8 * U;
    end else if (mode < 80) begin
      // degenerate: repeated vertex or collinear c
      k = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        if (k == 0) r[6+i] = r[3+i];
        else if (k == 1) r[9+i] = r[6+i];
        else r[9+i] = r[3+i] + 2 * (r[6+i] - r[3+i]) / 3;
      end
    end else if (mode < 90) begin
      // p sits on a vertex
      k = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++) r[i] = r[3*k+i];
    end
    return r;
  endfunction

  function automatic tri_req_t mk_req(input coord_t p0, p1, p2, a0, a1, a2,
                                      b0, b1, b2, c0, c1, c2);
    tri_req_t r;
    r = '{p0, p1, p2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return r;
  endfunction

  task automatic add_row(input tri_req_t r, input bit typed, input coord_t x, y, z,
                         input logic [2:0] f);
    stim_row_t s;
    s.req = r;
    s.typed = typed;
    s.pt = '{x, y, z, f};
    stim_rows.push_back(s);
  endtask

  localparam coord_t MAXC = 32'sh7FFFFFFF;
  localparam coord_t MINC = 32'sh80000000;

  initial begin
    near_pt_t none;
    none = '{0, 0, 0, FEAT_A};
    rst_n = 1'b0;
    start = 1'b0;
    {in_px, in_py, in_pz, in_ax, in_ay, in_az} = '0;
    {in_bx, in_by, in_bz, in_cx, in_cy, in_cz} = '0;
    foreach (feat_seen[i]) feat_seen[i] = 0;

    // unit right triangle a=0, b=x, c=y for the hand-checked regions
    add_row(mk_req(0, 0, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 1, 0, 0, 0, FEAT_A);
    add_row(mk_req(5*U, 0, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 1, U, 0, 0, FEAT_B);
    add_row(mk_req(0, 5*U, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 1, 0, U, 0, FEAT_C);
    add_row(mk_req(U/2, -U, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 1, U/2, 0, 0, FEAT_AB);
    add_row(mk_req(-U, U/2, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 1, 0, U/2, 0, FEAT_AC);
    add_row(mk_req(U, U, 0, 0, 0, 0, U, 0, 0, 0, U, 0), 0, 0, 0, 0, FEAT_A);
    add_row(mk_req(U/4, U/4, U, 0, 0, 0, U, 0, 0, 0, U, 0), 0, 0, 0, 0, FEAT_A);
    add_row(mk_req(3, 7, -5, 1, 1, 1, 900, 2, 3, 4, 700, -9), 0, 0, 0, 0, FEAT_A);
    // everything at zero: both first dots are zero, so vertex a
    add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, FEAT_A);
    // collinear triangle, p off the line: vc is zero, so edge ab
    add_row(mk_req(U, U, 0, 0, 0, 0, 2*U, 0, 0, U, 0, 0), 0, 0, 0, 0, FEAT_A);
    add_row(mk_req(U, U, U, 0, 0, 0, 2*U, 0, 0, 3*U, 0, 0), 0, 0, 0, 0, FEAT_A);
    // repeated vertices: zero-length edges
    add_row(mk_req(U, 2*U, 0, 0, 0, 0, 0, 0, 0, U, 0, 0), 0, 0, 0, 0, FEAT_A);
    add_row(mk_req(U, 2*U, 0, 0, 0, 0, U, 0, 0, U, 0, 0), 0, 0, 0, 0, FEAT_A);
    // coordinate extremes
    add_row(mk_req(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                   MAXC, MAXC, MAXC), 1, MAXC, MAXC, MAXC, FEAT_A);
    add_row(mk_req(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                   MINC, MINC, MINC), 1, MINC, MINC, MINC, FEAT_A);
    add_row(mk_req(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC,
                   MINC, MINC, MAXC), 0, 0, 0, 0, FEAT_A);
    add_row(mk_req(0, 0, 0, MINC, MINC, MINC, MAXC, MINC, 0, MINC, MAXC, 0),
            0, 0, 0, 0, FEAT_A);
    add_row(mk_req(0, 0, MAXC, MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0),
            0, 0, 0, 0, FEAT_A);
    add_row(mk_req(MINC, MAXC, 0, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0),
            0, 0, 0, 0, FEAT_A);
    add_row(mk_req(-1, -1, -1, 1, 0, 0, 0, 1, 0, 0, 0, 1), 0, 0, 0, 0, FEAT_A);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].pt);
      gap(rand_gap());
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      send_req(rand_req(), 1'b0, none);
      if (n == DRAIN_AT) begin
        // hold off until the block has returned everything in flight
        gap(1);
        while (pending_pts.size() != 0) @(posedge clk);
      end else begin
        gap(rand_gap());
      end
    end

    gap(1);
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d requests sent, %0d results checked", n_sent, n_seen);
    $display("regions hit: a=%0d b=%0d ab=%0d c=%0d ac=%0d bc=%0d face=%0d",
             feat_seen[0], feat_seen[1], feat_seen[2], feat_seen[3],
             feat_seen[4], feat_seen[5], feat_seen[6]);
    if (n_err == 0 && pending_pts.size() == 0) begin
      $display("** closest_point_on_triangle: PASSED **");
    end else begin
      $display("** closest_point_on_triangle: FAILED **");
    end
    $finish;
  end

endmodule
